// ===== rtl/rfsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsq_pkg
// Shared sizes, operation and status codes, record type and index helper
// for the record queue with scan queries.
// ----------------------------------------------------------------------------
package rfsq_pkg;

    // Queue depth and the widths that follow from it.
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    // The price sum holds DEPTH prices of 32 bits without overflow.
    localparam int SUMW  = CW + 32;
    localparam int DCW   = $clog2(SUMW + 1);

    // Operation codes.
    localparam logic [2:0] OP_ENQ  = 3'd0;
    localparam logic [2:0] OP_DEQ  = 3'd1;
    localparam logic [2:0] OP_FIND = 3'd2;
    localparam logic [2:0] OP_MAX  = 3'd3;
    localparam logic [2:0] OP_MEAN = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // One stored record, 60 bits.
    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  doors;
        logic [31:0] price;
        logic [7:0]  series;
    } t_rec;

    // One result item as held before it is sent.
    typedef struct packed {
        logic [1:0]  status;
        t_rec        rec;
        logic [31:0] mean;
    } t_result;

    // Advance a circular index, wrapping at the queue depth.
    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

endpackage

// ===== rtl/rfsq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsq_if
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------

// Request channel: one operation with its record fields.
interface rfsq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] item_id;
    logic [3:0]  item_doors;
    logic [31:0] item_price;
    logic [7:0]  item_series;

    modport source (output valid, operation, item_id, item_doors, item_price,
                    item_series, input ready);
    modport sink   (input valid, operation, item_id, item_doors, item_price,
                    item_series, output ready);
endinterface

// Result channel: status, a returned record and the mean price.
interface rfsq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [3:0]  out_doors;
    logic [31:0] out_price;
    logic [7:0]  out_series;
    logic [31:0] mean_price;

    modport source (output valid, status, out_id, out_doors, out_price,
                    out_series, mean_price, input ready);
    modport sink   (input valid, status, out_id, out_doors, out_price,
                    out_series, mean_price, output ready);
endinterface

// ===== rtl/record_fifo_with_scan_queries_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_fifo_with_scan_queries_top
// Bounded record queue with find, max and mean queries over its contents.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_in (valid/ready), each with an operation code and
//   record fields. Every request gives exactly one result item on o_out.
//   The block takes one request at a time; i_in.ready is high only while the
//   sequencer is idle, and it may be high while an earlier result still
//   waits in the output register.
//   Enqueue and unknown codes go straight to the result; dequeue reads the
//   oldest record; find and max make one memory read per stored record.
//   Mean scans the same way, and the quotient comes from a restoring divider
//   that takes one bit a cycle through the same adder that sums prices.
//   Throughput is set by the single memory read port during scans and by
//   the shared adder/subtractor during the division.
//   If the receiver stalls, the result stays in the output register and the
//   next request may be accepted; its result waits until the register frees.
//   Reset (synchronous, active low) empties the queue; the record memory
//   itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module record_fifo_with_scan_queries_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfsq_in_if.sink    i_in,
    rfsq_out_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int AW   = rfsq_pkg::AW;
    localparam int CW   = rfsq_pkg::CW;
    localparam int SUMW = rfsq_pkg::SUMW;
    localparam int DCW  = rfsq_pkg::DCW;

    // Record memory.
    rfsq_pkg::t_rec mem [rfsq_pkg::DEPTH];

    // Control registers.
    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic [AW-1:0]     r_wr_idx, n_wr_idx;
    logic [CW-1:0]     r_fill, n_fill;
    logic              r_out_valid, n_out_valid;
    logic              r_issue, n_issue;

    // Working registers.
    logic [2:0]        r_op, n_op;
    logic [15:0]       r_key, n_key;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_limit, n_limit;
    logic [AW-1:0]     r_pos, n_pos;
    logic              r_first, n_first;
    logic              r_hit, n_hit;
    logic [SUMW-1:0]   r_sum, n_sum;
    logic [CW-1:0]     r_rem, n_rem;
    logic [DCW-1:0]    r_dcnt, n_dcnt;
    rfsq_pkg::t_rec    r_best, n_best;
    rfsq_pkg::t_result r_res, n_res;
    rfsq_pkg::t_result r_out, n_out;
    rfsq_pkg::t_rec    r_rd;

    logic              acc;
    logic              full;
    logic              mem_we;
    logic              rd_en;
    rfsq_pkg::t_rec    wr_rec;

    // Shared adder/subtractor.
    logic [SUMW-1:0]   alu_a, alu_b;
    logic              alu_sub;
    logic [SUMW:0]     alu_res;
    logic [CW:0]       div_t;
    logic              div_q;

    assign i_in.ready = (r_state == S_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign full       = (r_fill == CW'(rfsq_pkg::DEPTH));

    assign wr_rec.id     = i_in.item_id;
    assign wr_rec.doors  = i_in.item_doors;
    assign wr_rec.price  = i_in.item_price;
    assign wr_rec.series = i_in.item_series;

    // Division step: bring the next dividend bit into the remainder.
    assign div_t = {r_rem, r_sum[SUMW-1]};
    assign div_q = !alu_res[SUMW];

    // Operand selection for the shared unit.
    always_comb begin
        if (r_state == S_DIV) begin
            alu_a   = SUMW'(div_t);
            alu_b   = SUMW'(r_limit);
            alu_sub = 1'b1;
        end else if (r_op == rfsq_pkg::OP_MAX) begin
            alu_a   = SUMW'(r_best.price);
            alu_b   = SUMW'(r_rd.price);
            alu_sub = 1'b1;
        end else begin
            alu_a   = r_sum;
            alu_b   = SUMW'(r_rd.price);
            alu_sub = 1'b0;
        end
        alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                          : ({1'b0, alu_a} + {1'b0, alu_b});
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !o_out.ready;
        n_issue     = 1'b0;
        n_op        = r_op;
        n_key       = r_key;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_pos       = r_pos;
        n_first     = r_first;
        n_hit       = r_hit;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_best      = r_best;
        n_res       = r_res;
        n_out       = r_out;
        mem_we      = 1'b0;
        rd_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_op    = i_in.operation;
                    n_key   = i_in.item_id;
                    n_first = 1'b1;
                    n_hit   = 1'b0;
                    n_cnt   = '0;
                    n_pos   = r_rd_idx;
                    n_sum   = '0;
                    n_limit = (i_in.operation == rfsq_pkg::OP_DEQ) ? CW'(1) : r_fill;
                    n_res   = '0;
                    n_state = S_DONE;
                    unique case (i_in.operation)
                        rfsq_pkg::OP_ENQ: begin
                            if (full) begin
                                n_res.status = rfsq_pkg::ST_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                n_wr_idx = rfsq_pkg::next_slot(r_wr_idx);
                                n_fill   = r_fill + CW'(1);
                            end
                        end
                        rfsq_pkg::OP_DEQ, rfsq_pkg::OP_MAX, rfsq_pkg::OP_MEAN: begin
                            if (r_fill == '0) begin
                                n_res.status = rfsq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        rfsq_pkg::OP_FIND: begin
                            if (r_fill == '0) begin
                                n_res.status = rfsq_pkg::ST_NOTFOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // Unknown codes: plain OK result, state untouched.
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue one read per cycle until the limit is reached.
                if (r_cnt != r_limit) begin
                    rd_en   = 1'b1;
                    n_issue = 1'b1;
                    n_pos   = rfsq_pkg::next_slot(r_pos);
                    n_cnt   = r_cnt + CW'(1);
                end
                // Consume the record read in the previous cycle.
                if (r_issue) begin
                    n_first = 1'b0;
                    unique case (r_op)
                        rfsq_pkg::OP_FIND: begin
                            if (r_rd.id == r_key) begin
                                n_hit  = 1'b1;
                                n_best = r_rd;
                            end
                        end
                        rfsq_pkg::OP_MAX: begin
                            // Strictly higher price replaces, so the oldest wins ties.
                            if (r_first || alu_res[SUMW]) begin
                                n_best = r_rd;
                            end
                        end
                        rfsq_pkg::OP_MEAN: begin
                            n_sum = alu_res[SUMW-1:0];
                        end
                        default: begin
                            n_best = r_rd;
                        end
                    endcase
                end
                // All reads issued and consumed: form the result.
                if (r_cnt == r_limit && !r_issue) begin
                    n_state = S_DONE;
                    unique case (r_op)
                        rfsq_pkg::OP_DEQ: begin
                            n_res.rec = r_best;
                            n_rd_idx  = rfsq_pkg::next_slot(r_rd_idx);
                            n_fill    = r_fill - CW'(1);
                        end
                        rfsq_pkg::OP_FIND: begin
                            if (r_hit) begin
                                n_res.rec = r_best;
                            end else begin
                                n_res.status = rfsq_pkg::ST_NOTFOUND;
                            end
                        end
                        rfsq_pkg::OP_MAX: begin
                            n_res.rec = r_best;
                        end
                        default: begin
                            n_state = S_DIV;
                            n_rem   = '0;
                            n_dcnt  = '0;
                        end
                    endcase
                end
            end

            S_DIV: begin
                // One quotient bit per cycle; quotient bits shift into the sum.
                n_sum  = {r_sum[SUMW-2:0], div_q};
                n_rem  = div_q ? alu_res[CW-1:0] : div_t[CW-1:0];
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(SUMW - 1)) begin
                    n_res.mean = n_sum[31:0];
                    n_state    = S_DONE;
                end
            end

            S_DONE: begin
                // Move the result out once the output register is free.
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_issue     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_issue     <= n_issue;
        end
        r_op    <= n_op;
        r_key   <= n_key;
        r_cnt   <= n_cnt;
        r_limit <= n_limit;
        r_pos   <= n_pos;
        r_first <= n_first;
        r_hit   <= n_hit;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_best  <= n_best;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_idx] <= wr_rec;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[r_pos];
        end
    end

    // Output channel.
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.out_id     = r_out.rec.id;
    assign o_out.out_doors  = r_out.rec.doors;
    assign o_out.out_price  = r_out.rec.price;
    assign o_out.out_series = r_out.rec.series;
    assign o_out.mean_price = r_out.mean;

    // Checks.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(rfsq_pkg::DEPTH))
        else $error("fill count exceeds depth");

    a_idx_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == CW'(rfsq_pkg::DEPTH)) |-> (r_rd_idx == r_wr_idx))
        else $error("read and write indices disagree with fill count");

    a_enq_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.operation == rfsq_pkg::OP_ENQ && !full)
        |=> (r_fill == CW'($past(r_fill) + CW'(1))))
        else $error("enqueue did not grow the queue");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_limit))
        else $error("divider remainder not below divisor");

endmodule

// ===== dv/record_fifo_with_scan_queries_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_fifo_with_scan_queries_top_tb
// Self-checking bench for the record queue with find, max and mean queries.
// A short table of directed requests covers the empty queue, unused codes,
// extreme field values, duplicate ids and price ties. Random phases follow:
// they fill the queue past full, drain it past empty and mix in queries.
// A shadow copy of the queue predicts every result item that the table does
// not give, and the results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module record_fifo_with_scan_queries_top_tb;

    // Codes that the block ignores.
    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 150;
    localparam int N_DIRECTED   = 24;
    localparam int SUMW         = rfsq_pkg::SUMW;

    // Results that are fixed without looking at the queue contents.
    localparam rfsq_pkg::t_result EXP_OK =
        '{status: rfsq_pkg::ST_OK, rec: '0, mean: '0};
    localparam rfsq_pkg::t_result EXP_EMPTY =
        '{status: rfsq_pkg::ST_EMPTY, rec: '0, mean: '0};
    localparam rfsq_pkg::t_result EXP_NOTFOUND =
        '{status: rfsq_pkg::ST_NOTFOUND, rec: '0, mean: '0};

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_QUERY} t_phase;

    typedef struct packed {
        logic [2:0]     op;
        rfsq_pkg::t_rec rec;
    } t_req;

    // One directed row: request fields, and a typed result where typed is set.
    typedef struct packed {
        logic [2:0]        op;
        logic [15:0]       id;
        logic [3:0]        doors;
        logic [31:0]       price;
        logic [7:0]        series;
        logic              typed;
        rfsq_pkg::t_result want;
    } t_row;

    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Every query on an empty queue.
        '{rfsq_pkg::OP_DEQ,  16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b1, EXP_EMPTY},
        '{rfsq_pkg::OP_FIND, 16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b1, EXP_NOTFOUND},
        '{rfsq_pkg::OP_MAX,  16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1, EXP_EMPTY},
        '{rfsq_pkg::OP_MEAN, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1, EXP_EMPTY},
        // Unused codes return zeros and leave the queue alone.
        '{OP_UNUSED_5,       16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1, EXP_OK},
        '{OP_UNUSED_6,       16'hA5A5, 4'hA, 32'h5A5A_5A5A, 8'hA5, 1'b1, EXP_OK},
        '{OP_UNUSED_7,       16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b1, EXP_OK},
        // Extreme records, a price tie and a duplicate id.
        '{rfsq_pkg::OP_ENQ,  16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1, EXP_OK},
        '{rfsq_pkg::OP_ENQ,  16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b1, EXP_OK},
        '{rfsq_pkg::OP_ENQ,  16'h1234, 4'h5, 32'hFFFF_FFFF, 8'h41, 1'b1, EXP_OK},
        '{rfsq_pkg::OP_ENQ,  16'hFFFF, 4'h3, 32'h0000_0064, 8'h07, 1'b1, EXP_OK},
        '{rfsq_pkg::OP_FIND, 16'hFFFF, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_FIND, 16'h0000, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0},
        '{rfsq_pkg::OP_FIND, 16'h5555, 4'h0, 32'h0000_0000, 8'h00, 1'b1, EXP_NOTFOUND},
        '{rfsq_pkg::OP_MAX,  16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_MEAN, 16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_DEQ,  16'hBEEF, 4'h9, 32'h1234_5678, 8'h3C, 1'b0, '0},
        '{rfsq_pkg::OP_MAX,  16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_DEQ,  16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_DEQ,  16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_MEAN, 16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_DEQ,  16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{rfsq_pkg::OP_DEQ,  16'hFFFF, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1, EXP_EMPTY},
        '{rfsq_pkg::OP_MEAN, 16'h0000, 4'h0, 32'h0000_0000, 8'h00, 1'b1, EXP_EMPTY}
    };

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatch_count;

    // Shadow copy of the queue, oldest record first.
    rfsq_pkg::t_rec    shadow_recs[$];
    // Results still to come, in request order.
    rfsq_pkg::t_result awaited_results[$];

    rfsq_in_if  req_if ();
    rfsq_out_if res_if ();

    record_fifo_with_scan_queries_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Clock with a 20 ns period.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Apply one accepted request to the shadow queue and return its result.
    function automatic rfsq_pkg::t_result predict_queue_op(input t_req req);
        rfsq_pkg::t_result res;
        int                best;
        logic [SUMW-1:0]   total;
        res = '0;
        case (req.op)
            rfsq_pkg::OP_ENQ: begin
                if (shadow_recs.size() >= rfsq_pkg::DEPTH) begin
                    res.status = rfsq_pkg::ST_FULL;
                end else begin
                    shadow_recs.push_back(req.rec);
                end
            end
            rfsq_pkg::OP_DEQ: begin
                if (shadow_recs.size() == 0) begin
                    res.status = rfsq_pkg::ST_EMPTY;
                end else begin
                    res.rec = shadow_recs.pop_front();
                end
            end
            rfsq_pkg::OP_FIND: begin
                // The newest match wins, so keep overwriting while walking.
                res.status = rfsq_pkg::ST_NOTFOUND;
                foreach (shadow_recs[k]) begin
                    if (shadow_recs[k].id == req.rec.id) begin
                        res.status = rfsq_pkg::ST_OK;
                        res.rec    = shadow_recs[k];
                    end
                end
            end
            rfsq_pkg::OP_MAX: begin
                if (shadow_recs.size() == 0) begin
                    res.status = rfsq_pkg::ST_EMPTY;
                end else begin
                    // A strict compare keeps the oldest of equal prices.
                    best = 0;
                    foreach (shadow_recs[k]) begin
                        if (shadow_recs[k].price > shadow_recs[best].price) best = k;
                    end
                    res.rec = shadow_recs[best];
                end
            end
            rfsq_pkg::OP_MEAN: begin
                if (shadow_recs.size() == 0) begin
                    res.status = rfsq_pkg::ST_EMPTY;
                end else begin
                    total = '0;
                    foreach (shadow_recs[k]) total += SUMW'(shadow_recs[k].price);
                    res.mean = 32'(total / SUMW'(shadow_recs.size()));
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Ids come mostly from a small pool so that find sees duplicates.
    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom_range(0, 7));
            2:       return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_price(input bit all_ones);
        if (all_ones) return '1;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    // Draw one request; the phase sets the balance of enqueues and dequeues.
    function automatic t_req random_request(input t_phase phase, input bit all_ones);
        t_req req;
        int   enq_pct;
        int   deq_pct;
        int   roll;
        case (phase)
            PH_FILL:  begin enq_pct = 65; deq_pct = 10; end
            PH_DRAIN: begin enq_pct = 20; deq_pct = 55; end
            PH_MIXED: begin enq_pct = 35; deq_pct = 30; end
            default:  begin enq_pct = 20; deq_pct = 15; end
        endcase
        req.rec.id     = pick_id();
        req.rec.doors  = 4'($urandom);
        req.rec.price  = pick_price(all_ones);
        req.rec.series = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            req.op = 3'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
        end else if (roll < 3 + enq_pct) begin
            req.op = rfsq_pkg::OP_ENQ;
        end else if (roll < 3 + enq_pct + deq_pct) begin
            req.op = rfsq_pkg::OP_DEQ;
        end else begin
            case ($urandom_range(0, 2))
                0:       req.op = rfsq_pkg::OP_FIND;
                1:       req.op = rfsq_pkg::OP_MAX;
                default: req.op = rfsq_pkg::OP_MEAN;
            endcase
        end
        // Most find keys hit a stored record.
        if (req.op == rfsq_pkg::OP_FIND && shadow_recs.size() != 0
            && $urandom_range(0, 2) != 0) begin
            req.rec.id = shadow_recs[$urandom_range(0, shadow_recs.size() - 1)].id;
        end
        return req;
    endfunction

    // Present one request, with random gaps, and record its expected result.
    task automatic send_request(input t_req req, input bit typed,
                                input rfsq_pkg::t_result want);
        rfsq_pkg::t_result predicted;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 36) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= req.op;
        req_if.item_id     <= req.rec.id;
        req_if.item_doors  <= req.rec.doors;
        req_if.item_price  <= req.rec.price;
        req_if.item_series <= req.rec.series;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        predicted = predict_queue_op(req);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // Hold the request side quiet until every result has arrived.
    task automatic wait_all_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // The result side stalls at random except during calm stretches.
    always @(negedge clk) begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= 36);
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge clk) begin : check_results
        rfsq_pkg::t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t ns: result item with none expected, status %0d",
                         $time, res_if.status);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", 32'(want.status), 32'(res_if.status));
                check_field("out_id", 32'(want.rec.id), 32'(res_if.out_id));
                check_field("out_doors", 32'(want.rec.doors), 32'(res_if.out_doors));
                check_field("out_price", want.rec.price, res_if.out_price);
                check_field("out_series", 32'(want.rec.series), 32'(res_if.out_series));
                check_field("mean_price", want.mean, res_if.mean_price);
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin : stimulus
        t_req   req;
        t_phase phase;
        int     phase_no;
        int     phase_len;
        int     sent_count;
        bit     all_ones;
        mismatch_count      = 0;
        calm                = 1'b0;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.operation    = '0;
        req_if.item_id      = '0;
        req_if.item_doors   = '0;
        req_if.item_price   = '0;
        req_if.item_series  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < N_DIRECTED; n++) begin
            req.op         = DIRECTED_ROWS[n].op;
            req.rec.id     = DIRECTED_ROWS[n].id;
            req.rec.doors  = DIRECTED_ROWS[n].doors;
            req.rec.price  = DIRECTED_ROWS[n].price;
            req.rec.series = DIRECTED_ROWS[n].series;
            send_request(req, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
        end
        wait_all_results();

        // Random phases; the third one runs without gaps on either side.
        phase_no   = 0;
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            phase     = t_phase'($urandom_range(0, 3));
            phase_len = $urandom_range(40, 160);
            all_ones  = ($urandom_range(0, 5) == 0);
            if (phase_no == 2) begin
                phase     = PH_FILL;
                phase_len = 200;
            end
            calm <= (phase_no == 2) || ($urandom_range(0, 7) == 0);
            for (int n = 0; n < phase_len && sent_count < RANDOM_ITEMS; n++) begin
                req = random_request(phase, all_ones);
                send_request(req, 1'b0, '0);
                sent_count++;
            end
            if ($urandom_range(0, 3) == 0) wait_all_results();
            phase_no++;
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("PASS record_fifo_with_scan_queries_top");
        end else begin
            $display("FAIL record_fifo_with_scan_queries_top");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #30_000_000;
        $display("FAIL record_fifo_with_scan_queries_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rfsq_pkg.sv
rtl/rfsq_if.sv
rtl/record_fifo_with_scan_queries_top.sv
dv/record_fifo_with_scan_queries_top_tb.sv
